// ===== rtl/core/segi_pkg.sv =====
// Package for the segment intersection block: transfer payload types and fixed sizes.
// Used by segi_div and segment_intersection_top. It depends on nothing else.
`timescale 1ns / 1ps

package segi_pkg;

   localparam int COORD_BITS = 16;
   localparam int OUT_BITS   = 32;

   typedef struct packed {
      logic signed [COORD_BITS-1:0] a_start_x;
      logic signed [COORD_BITS-1:0] a_start_y;
      logic signed [COORD_BITS-1:0] a_end_x;
      logic signed [COORD_BITS-1:0] a_end_y;
      logic signed [COORD_BITS-1:0] b_start_x;
      logic signed [COORD_BITS-1:0] b_start_y;
      logic signed [COORD_BITS-1:0] b_end_x;
      logic signed [COORD_BITS-1:0] b_end_y;
   } req_type;

   typedef struct packed {
      logic                       hit;
      logic                       coincident;
      logic signed [OUT_BITS-1:0] cross_x;
      logic signed [OUT_BITS-1:0] cross_y;
   } rsp_type;

   typedef struct packed {
      logic hit;
      logic coincident;
      logic neg_x;
      logic neg_y;
   } side_type;

endpackage

// ===== rtl/core/segment_intersection_top.sv =====
// Segment intersection top level: cross products, classification and the fixed point crossing.
// Depends on segi_pkg and segi_div.
//
//   channel   ports                          transfer
//   request   start, busy, req_data          edge with start high and busy low
//   response  rsp_valid, rsp_data            every cycle with rsp_valid high
//
// One pair can be taken in every cycle; busy is always low.
// The divider has COORD_BITS + FRAC_BITS stages and sits between stage six and the output stage.
// It produces one quotient bit a stage.
// Reset clears only the valid bits, so any transfers in flight are dropped.
// The receiver cannot stall, so the pipeline never holds.
`timescale 1ns / 1ps

module segment_intersection_top #(
   parameter int FRAC_BITS = 16
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  segi_pkg::req_type  req_data,
   output logic               rsp_valid,
   output segi_pkg::rsp_type  rsp_data
);

   localparam int C    = segi_pkg::COORD_BITS;
   localparam int OW   = segi_pkg::OUT_BITS;
   localparam int DW   = C + 1;
   localparam int PW   = 2 * DW;
   localparam int SW   = 2 * C + 3;
   localparam int DENW = 2 * C + 2;
   localparam int MXW  = C + SW;
   localparam int TXW  = DW + SW;
   localparam int NUMW = 3 * C + 5;
   localparam int NW   = NUMW + FRAC_BITS;
   localparam int QW   = C + FRAC_BITS;
   localparam int EW   = (QW > OW) ? QW : OW + 1;
   localparam int LAT  = QW + 7;

   assign busy = 1'b0;

   // Stage 1: differences and bounding range tests.
   logic                 s1_vld_ff;
   logic signed [DW-1:0] s1_dxa_ff, s1_dya_ff, s1_dxb_ff, s1_dyb_ff, s1_wx_ff, s1_wy_ff;
   logic signed [C-1:0]  s1_ax_ff, s1_ay_ff, s1_bx_ff, s1_by_ff;
   logic                 s1_ainb_ff, s1_bina_ff;
   logic                 s1_ainb_in, s1_bina_in;

   always_comb begin
      s1_ainb_in = (req_data.a_start_x >= req_data.b_start_x &&
                    req_data.a_start_x <= req_data.b_end_x) ||
                   (req_data.a_start_x >= req_data.b_end_x &&
                    req_data.a_start_x <= req_data.b_start_x);
      s1_bina_in = (req_data.b_start_x >= req_data.a_start_x &&
                    req_data.b_start_x <= req_data.a_end_x) ||
                   (req_data.b_start_x >= req_data.a_end_x &&
                    req_data.b_start_x <= req_data.a_start_x);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff <= 1'b0;
      end else begin
         s1_vld_ff <= start & ~busy;
      end
   end

   always_ff @(posedge clock) begin
      s1_dxa_ff  <= DW'(req_data.a_end_x) - DW'(req_data.a_start_x);
      s1_dya_ff  <= DW'(req_data.a_end_y) - DW'(req_data.a_start_y);
      s1_dxb_ff  <= DW'(req_data.b_end_x) - DW'(req_data.b_start_x);
      s1_dyb_ff  <= DW'(req_data.b_end_y) - DW'(req_data.b_start_y);
      s1_wx_ff   <= DW'(req_data.b_start_x) - DW'(req_data.a_start_x);
      s1_wy_ff   <= DW'(req_data.b_start_y) - DW'(req_data.a_start_y);
      s1_ax_ff   <= req_data.a_start_x;
      s1_ay_ff   <= req_data.a_start_y;
      s1_bx_ff   <= req_data.b_start_x;
      s1_by_ff   <= req_data.b_start_y;
      s1_ainb_ff <= s1_ainb_in;
      s1_bina_ff <= s1_bina_in;
   end

   // Stage 2: the six cross products.
   logic                 s2_vld_ff;
   logic signed [PW-1:0] s2_p1_ff, s2_p2_ff, s2_p3_ff, s2_p4_ff, s2_p5_ff, s2_p6_ff;
   logic signed [PW-1:0] s2_p1_in, s2_p2_in, s2_p3_in, s2_p4_in, s2_p5_in, s2_p6_in;
   logic                 s2_va_ff, s2_vb_ff, s2_wx0_ff;
   logic signed [DW-1:0] s2_dxa_ff, s2_dya_ff;
   logic signed [C-1:0]  s2_ax_ff, s2_ay_ff, s2_bx_ff, s2_by_ff;
   logic                 s2_ainb_ff, s2_bina_ff;

   always_comb begin
      s2_p1_in = s1_dxa_ff * s1_dyb_ff;
      s2_p2_in = s1_dya_ff * s1_dxb_ff;
      s2_p3_in = s1_wy_ff * s1_dxa_ff;
      s2_p4_in = s1_dya_ff * s1_wx_ff;
      s2_p5_in = s1_wx_ff * s1_dyb_ff;
      s2_p6_in = s1_wy_ff * s1_dxb_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_vld_ff <= 1'b0;
      end else begin
         s2_vld_ff <= s1_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      s2_p1_ff   <= s2_p1_in;
      s2_p2_ff   <= s2_p2_in;
      s2_p3_ff   <= s2_p3_in;
      s2_p4_ff   <= s2_p4_in;
      s2_p5_ff   <= s2_p5_in;
      s2_p6_ff   <= s2_p6_in;
      s2_va_ff   <= s1_dxa_ff == '0;
      s2_vb_ff   <= s1_dxb_ff == '0;
      s2_wx0_ff  <= s1_wx_ff == '0;
      s2_dxa_ff  <= s1_dxa_ff;
      s2_dya_ff  <= s1_dya_ff;
      s2_ax_ff   <= s1_ax_ff;
      s2_ay_ff   <= s1_ay_ff;
      s2_bx_ff   <= s1_bx_ff;
      s2_by_ff   <= s1_by_ff;
      s2_ainb_ff <= s1_ainb_ff;
      s2_bina_ff <= s1_bina_ff;
   end

   // Stage 3: determinant, parameters and classification.
   logic                 s3_vld_ff;
   logic signed [SW-1:0] s3_den_ff, s3_tn_ff, s3_un_ff;
   logic                 s3_par_ff, s3_coin_ff, s3_pt_ff, s3_on_ff;
   logic signed [C-1:0]  s3_bx_ff, s3_by_ff;
   logic signed [DW-1:0] s3_dx_ff, s3_dy_ff;
   logic                 s3_par_in, s3_coin_in, s3_pt_in, s3_on_in;
   logic signed [SW-1:0] s3_den_in, s3_tn_in, s3_un_in;

   always_comb begin
      s3_par_in  = (s2_va_ff & s2_vb_ff) |
                   (~s2_va_ff & ~s2_vb_ff & (s2_p1_ff == s2_p2_ff));
      s3_coin_in = (s2_va_ff & s2_vb_ff) ? s2_wx0_ff : (s2_p3_ff == s2_p4_ff);
      s3_pt_in   = ~s3_par_in & (s2_p1_ff == s2_p2_ff);
      s3_on_in   = s2_va_ff ? ((s2_p5_ff == s2_p6_ff) & s2_ainb_ff)
                            : ((s2_p3_ff == s2_p4_ff) & s2_bina_ff);
      if (s3_pt_in) begin
         s3_den_in = SW'(1);
         s3_tn_in  = '0;
         s3_un_in  = '0;
      end else begin
         s3_den_in = SW'(s2_p1_ff) - SW'(s2_p2_ff);
         s3_tn_in  = SW'(s2_p5_ff) - SW'(s2_p6_ff);
         s3_un_in  = SW'(s2_p4_ff) - SW'(s2_p3_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_vld_ff <= 1'b0;
      end else begin
         s3_vld_ff <= s2_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      s3_den_ff  <= s3_den_in;
      s3_tn_ff   <= s3_tn_in;
      s3_un_ff   <= s3_un_in;
      s3_par_ff  <= s3_par_in;
      s3_coin_ff <= s3_coin_in;
      s3_pt_ff   <= s3_pt_in;
      s3_on_ff   <= s3_on_in;
      s3_bx_ff   <= (s3_pt_in & ~s2_va_ff) ? s2_bx_ff : s2_ax_ff;
      s3_by_ff   <= (s3_pt_in & ~s2_va_ff) ? s2_by_ff : s2_ay_ff;
      s3_dx_ff   <= s2_dxa_ff;
      s3_dy_ff   <= s2_dya_ff;
   end

   // Stage 4: make the determinant non-negative.
   logic                 s4_vld_ff;
   logic signed [SW-1:0] s4_den_ff, s4_tn_ff, s4_un_ff;
   logic                 s4_par_ff, s4_coin_ff, s4_pt_ff, s4_on_ff;
   logic signed [C-1:0]  s4_bx_ff, s4_by_ff;
   logic signed [DW-1:0] s4_dx_ff, s4_dy_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s4_vld_ff <= 1'b0;
      end else begin
         s4_vld_ff <= s3_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      s4_den_ff  <= s3_den_ff[SW-1] ? -s3_den_ff : s3_den_ff;
      s4_tn_ff   <= s3_den_ff[SW-1] ? -s3_tn_ff : s3_tn_ff;
      s4_un_ff   <= s3_den_ff[SW-1] ? -s3_un_ff : s3_un_ff;
      s4_par_ff  <= s3_par_ff;
      s4_coin_ff <= s3_coin_ff;
      s4_pt_ff   <= s3_pt_ff;
      s4_on_ff   <= s3_on_ff;
      s4_bx_ff   <= s3_bx_ff;
      s4_by_ff   <= s3_by_ff;
      s4_dx_ff   <= s3_dx_ff;
      s4_dy_ff   <= s3_dy_ff;
   end

   // Stage 5: range test and numerator products.
   logic                  s5_vld_ff;
   logic                  s5_hit_ff, s5_coin_ff;
   logic [DENW-1:0]       s5_den_ff;
   logic signed [MXW-1:0] s5_mx_ff, s5_my_ff, s5_mx_in, s5_my_in;
   logic signed [TXW-1:0] s5_tx_ff, s5_ty_ff, s5_tx_in, s5_ty_in;
   logic                  s5_ok_in, s5_hit_in;

   always_comb begin
      s5_ok_in  = ~s4_tn_ff[SW-1] & (s4_tn_ff <= s4_den_ff) &
                  ~s4_un_ff[SW-1] & (s4_un_ff <= s4_den_ff);
      s5_hit_in = s4_par_ff ? s4_coin_ff : (s4_pt_ff ? s4_on_ff : s5_ok_in);
      s5_mx_in  = s4_bx_ff * s4_den_ff;
      s5_my_in  = s4_by_ff * s4_den_ff;
      s5_tx_in  = s4_dx_ff * s4_tn_ff;
      s5_ty_in  = s4_dy_ff * s4_tn_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s5_vld_ff <= 1'b0;
      end else begin
         s5_vld_ff <= s4_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      s5_hit_ff  <= s5_hit_in;
      s5_coin_ff <= s4_par_ff & s4_coin_ff;
      s5_den_ff  <= s4_den_ff[DENW-1:0];
      s5_mx_ff   <= s5_mx_in;
      s5_my_ff   <= s5_my_in;
      s5_tx_ff   <= s5_tx_in;
      s5_ty_ff   <= s5_ty_in;
   end

   // Stage 6: numerators as sign and scaled magnitude.
   logic                   s6_vld_ff;
   logic [DENW-1:0]        s6_den_ff;
   logic [NW-1:0]          s6_nx_ff, s6_ny_ff;
   segi_pkg::side_type     s6_side_ff, s6_side_in;
   logic signed [NUMW-1:0] s6_sx_in, s6_sy_in;
   logic [NUMW-1:0]        s6_ax_in, s6_ay_in;

   always_comb begin
      s6_sx_in            = NUMW'(s5_mx_ff) + NUMW'(s5_tx_ff);
      s6_sy_in            = NUMW'(s5_my_ff) + NUMW'(s5_ty_ff);
      s6_ax_in            = s6_sx_in[NUMW-1] ? NUMW'(-s6_sx_in) : NUMW'(s6_sx_in);
      s6_ay_in            = s6_sy_in[NUMW-1] ? NUMW'(-s6_sy_in) : NUMW'(s6_sy_in);
      s6_side_in.hit        = s5_hit_ff;
      s6_side_in.coincident = s5_coin_ff;
      s6_side_in.neg_x      = s6_sx_in[NUMW-1];
      s6_side_in.neg_y      = s6_sy_in[NUMW-1];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s6_vld_ff <= 1'b0;
      end else begin
         s6_vld_ff <= s5_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      s6_den_ff  <= s5_den_ff;
      s6_nx_ff   <= NW'(s6_ax_in) << FRAC_BITS;
      s6_ny_ff   <= NW'(s6_ay_in) << FRAC_BITS;
      s6_side_ff <= s6_side_in;
   end

   // Division pipeline.
   logic               dv_valid;
   logic [QW-1:0]      dv_qx, dv_qy;
   segi_pkg::side_type dv_side;

   segi_div #(
      .NW   (NW),
      .DENW (DENW),
      .QW   (QW)
   ) u_div (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (s6_vld_ff),
      .in_den    (s6_den_ff),
      .in_num_x  (s6_nx_ff),
      .in_num_y  (s6_ny_ff),
      .in_side   (s6_side_ff),
      .out_valid (dv_valid),
      .out_q_x   (dv_qx),
      .out_q_y   (dv_qy),
      .out_side  (dv_side)
   );

   // Output stage: sign, saturation and masking.
   logic              out_vld_ff;
   segi_pkg::rsp_type out_ff, out_in;
   logic [EW-1:0]     qx_ext, qy_ext;
   logic [OW-1:0]     fx, fy;
   logic              show;

   always_comb begin
      qx_ext = EW'(dv_qx);
      qy_ext = EW'(dv_qy);
      if (dv_side.neg_x) begin
         fx = (qx_ext > EW'({1'b1, {(OW-1){1'b0}}})) ? {1'b1, {(OW-1){1'b0}}}
                                                     : OW'(-qx_ext);
      end else begin
         fx = (qx_ext > EW'({1'b0, {(OW-1){1'b1}}})) ? {1'b0, {(OW-1){1'b1}}}
                                                     : qx_ext[OW-1:0];
      end
      if (dv_side.neg_y) begin
         fy = (qy_ext > EW'({1'b1, {(OW-1){1'b0}}})) ? {1'b1, {(OW-1){1'b0}}}
                                                     : OW'(-qy_ext);
      end else begin
         fy = (qy_ext > EW'({1'b0, {(OW-1){1'b1}}})) ? {1'b0, {(OW-1){1'b1}}}
                                                     : qy_ext[OW-1:0];
      end
      show              = dv_side.hit & ~dv_side.coincident;
      out_in.hit        = dv_side.hit;
      out_in.coincident = dv_side.coincident;
      out_in.cross_x    = show ? fx : '0;
      out_in.cross_y    = show ? fy : '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_vld_ff <= 1'b0;
      end else begin
         out_vld_ff <= dv_valid;
      end
   end

   always_ff @(posedge clock) begin
      out_ff <= out_in;
   end

   assign rsp_valid = out_vld_ff;
   assign rsp_data  = out_ff;

   a_latency : assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |-> ##LAT rsp_valid)
      else $error("transfer did not produce a response after the pipeline latency");

   a_origin : assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(start, LAT))
      else $error("response without a matching request transfer");

   a_coin_hit : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.coincident) |-> rsp_data.hit)
      else $error("coincident response without hit");

   a_zero : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (!rsp_data.hit || rsp_data.coincident)) |->
      (rsp_data.cross_x == '0 && rsp_data.cross_y == '0))
      else $error("crossing fields not cleared");

endmodule

// ===== rtl/core/segi_div.sv =====
// Pipelined restoring divider: two numerators over one shared divisor, one quotient bit a stage.
// Depends on segi_pkg for the sideband type.
`timescale 1ns / 1ps

module segi_div #(
   parameter int NW   = 69,
   parameter int DENW = 34,
   parameter int QW   = 32
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                in_valid,
   input  logic [DENW-1:0]     in_den,
   input  logic [NW-1:0]       in_num_x,
   input  logic [NW-1:0]       in_num_y,
   input  segi_pkg::side_type  in_side,
   output logic                out_valid,
   output logic [QW-1:0]       out_q_x,
   output logic [QW-1:0]       out_q_y,
   output segi_pkg::side_type  out_side
);

   logic                vld_ff   [QW];
   logic [DENW-1:0]     den_ff   [QW];
   logic [DENW-1:0]     remx_ff  [QW];
   logic [DENW-1:0]     remy_ff  [QW];
   logic [QW-1:0]       nqx_ff   [QW];
   logic [QW-1:0]       nqy_ff   [QW];
   segi_pkg::side_type  side_ff  [QW];

   for (genvar i = 0; i < QW; i++) begin : g_step
      logic                vld_prev;
      logic [DENW-1:0]     den_prev;
      logic [DENW-1:0]     remx_prev;
      logic [DENW-1:0]     remy_prev;
      logic [QW-1:0]       nqx_prev;
      logic [QW-1:0]       nqy_prev;
      segi_pkg::side_type  side_prev;
      logic [DENW:0]       trial_x;
      logic [DENW:0]       trial_y;
      logic                ge_x;
      logic                ge_y;
      logic [DENW-1:0]     remx_in;
      logic [DENW-1:0]     remy_in;
      logic [QW-1:0]       nqx_in;
      logic [QW-1:0]       nqy_in;

      if (i == 0) begin : g_first
         assign vld_prev  = in_valid;
         assign den_prev  = in_den;
         assign remx_prev = DENW'(in_num_x[NW-1:QW]);
         assign remy_prev = DENW'(in_num_y[NW-1:QW]);
         assign nqx_prev  = in_num_x[QW-1:0];
         assign nqy_prev  = in_num_y[QW-1:0];
         assign side_prev = in_side;
      end else begin : g_next
         assign vld_prev  = vld_ff[i-1];
         assign den_prev  = den_ff[i-1];
         assign remx_prev = remx_ff[i-1];
         assign remy_prev = remy_ff[i-1];
         assign nqx_prev  = nqx_ff[i-1];
         assign nqy_prev  = nqy_ff[i-1];
         assign side_prev = side_ff[i-1];
      end

      always_comb begin
         trial_x = {remx_prev, nqx_prev[QW-1]};
         trial_y = {remy_prev, nqy_prev[QW-1]};
         ge_x    = trial_x >= {1'b0, den_prev};
         ge_y    = trial_y >= {1'b0, den_prev};
         remx_in = ge_x ? DENW'(trial_x - {1'b0, den_prev}) : trial_x[DENW-1:0];
         remy_in = ge_y ? DENW'(trial_y - {1'b0, den_prev}) : trial_y[DENW-1:0];
         nqx_in  = {nqx_prev[QW-2:0], ge_x};
         nqy_in  = {nqy_prev[QW-2:0], ge_y};
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[i] <= 1'b0;
         end else begin
            vld_ff[i] <= vld_prev;
         end
      end

      always_ff @(posedge clock) begin
         den_ff[i]  <= den_prev;
         remx_ff[i] <= remx_in;
         remy_ff[i] <= remy_in;
         nqx_ff[i]  <= nqx_in;
         nqy_ff[i]  <= nqy_in;
         side_ff[i] <= side_prev;
      end
   end

   assign out_valid = vld_ff[QW-1];
   assign out_q_x   = nqx_ff[QW-1];
   assign out_q_y   = nqy_ff[QW-1];
   assign out_side  = side_ff[QW-1];

endmodule
